FILE: hdl/spc_pkg.sv
// shared constants, codes and interface structs for the stable position capture block
// no dependencies
`default_nettype none

package spc_pkg;

    localparam int POSITION_WIDTH_DEF = 24;
    localparam int FRACTION_BITS_DEF  = 8;

    localparam int MODE_WIDTH  = 2;
    localparam int SEQ_WIDTH   = 8;
    localparam int PHASE_WIDTH = 2;
    localparam int COUNT_WIDTH = 8;
    localparam int LIMIT_WIDTH = 23;
    localparam int ADDR_WIDTH  = 4;
    localparam int DATA_WIDTH  = 32;

    localparam logic [MODE_WIDTH-1:0] MODE_FRAME  = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_START  = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_CANCEL = 2'd2;

    localparam logic [PHASE_WIDTH-1:0] PHASE_IDLE      = 2'd0;
    localparam logic [PHASE_WIDTH-1:0] PHASE_CAPTURING = 2'd1;
    localparam logic [PHASE_WIDTH-1:0] PHASE_CAPTURED  = 2'd2;

    localparam logic [1:0] REG_POSITION_LIMIT = 2'd0;
    localparam logic [1:0] REG_TOLERANCE      = 2'd1;
    localparam logic [1:0] REG_CONFIRM        = 2'd2;

    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET     = 23'd25600;
    localparam logic [LIMIT_WIDTH-1:0] TOLERANCE_RESET = 23'd512;
    localparam logic [COUNT_WIDTH-1:0] CONFIRM_RESET   = 8'd10;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX       = '1;

    typedef struct packed {
        logic [LIMIT_WIDTH-1:0] position_limit;
        logic [LIMIT_WIDTH-1:0] tolerance;
        logic [COUNT_WIDTH-1:0] confirm;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic check;
        logic div_start;
        logic accum;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic mean;
        logic div_done;
    } status_t;

endpackage

`default_nettype wire

FILE: hdl/stable_position_capture.sv
// top level of the stable position capture block
// depends on spc_pkg, spc_regs, spc_ctrl, spc_datapath
//
// usage
// one word in, one word out. an input word is a start command, a cancel command
// or a sensor frame (mode, frame_fresh, frame_sequence, position_valid, position).
// every accepted word yields one result word: phase, stable_frames and
// captured_target as they stand after that word.
// a word that leads to a mean update passes through eval, check, the serial
// divider, accum and commit before out_valid rises; the divider retires one
// quotient bit per cycle. every other word passes through eval, check and
// commit. one word is in work at a time, so a new word is taken only once
// the last one has been committed and the controller is back in idle.
// in_ready is high while no word is in work, even while a result waits.
// a finished result is held in the output register until out_ready; if the
// previous result is still waiting, the next one holds in commit until it is taken.
// reset clears the capture state to idle with a zero target and loads the
// default limit, tolerance and confirm count. configuration is written over the
// apb port at byte addresses 0, 4 and 8; pready is always high.
`default_nettype none

module stable_position_capture #(
    parameter int POSITION_WIDTH        = spc_pkg::POSITION_WIDTH_DEF,
    parameter int AVERAGE_FRACTION_BITS = spc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic        [spc_pkg::ADDR_WIDTH-1:0]  paddr,
    input  wire logic        [spc_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic             [spc_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                                        pready,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic        [spc_pkg::MODE_WIDTH-1:0]  mode,
    input  wire logic                                   frame_fresh,
    input  wire logic        [spc_pkg::SEQ_WIDTH-1:0]   frame_sequence,
    input  wire logic                                   position_valid,
    input  wire logic signed [POSITION_WIDTH-1:0]       position,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic             [spc_pkg::PHASE_WIDTH-1:0] phase,
    output logic             [spc_pkg::COUNT_WIDTH-1:0] stable_frames,
    output logic signed      [POSITION_WIDTH-1:0]       captured_target
);

    spc_pkg::cfg_t    cfg;
    spc_pkg::cmd_t    cmd;
    spc_pkg::status_t status;

    assign pready = 1'b1;

    spc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    spc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    spc_datapath #(
        .POSITION_WIDTH        (POSITION_WIDTH),
        .AVERAGE_FRACTION_BITS (AVERAGE_FRACTION_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg             (cfg),
        .mode            (mode),
        .frame_fresh     (frame_fresh),
        .frame_sequence  (frame_sequence),
        .position_valid  (position_valid),
        .position        (position),
        .phase           (phase),
        .stable_frames   (stable_frames),
        .captured_target (captured_target)
    );

endmodule

`default_nettype wire

FILE: hdl/spc_regs.sv
// configuration register file behind the apb-style port
// depends on spc_pkg
`default_nettype none

module spc_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [spc_pkg::ADDR_WIDTH-1:0] paddr,
    input  wire logic [spc_pkg::DATA_WIDTH-1:0] pwdata,
    output logic      [spc_pkg::DATA_WIDTH-1:0] prdata,
    output spc_pkg::cfg_t                       cfg
);

    logic [spc_pkg::LIMIT_WIDTH-1:0] limit_reg;
    logic [spc_pkg::LIMIT_WIDTH-1:0] tolerance_reg;
    logic [spc_pkg::COUNT_WIDTH-1:0] confirm_reg;
    logic                            wr;
    logic [1:0]                      index;

    assign wr    = psel && penable && pwrite;
    assign index = paddr[spc_pkg::ADDR_WIDTH-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= spc_pkg::LIMIT_RESET;
            tolerance_reg <= spc_pkg::TOLERANCE_RESET;
            confirm_reg   <= spc_pkg::CONFIRM_RESET;
        end
        else if (wr)
        begin
            case (index)
                spc_pkg::REG_POSITION_LIMIT: limit_reg     <= pwdata[spc_pkg::LIMIT_WIDTH-1:0];
                spc_pkg::REG_TOLERANCE:      tolerance_reg <= pwdata[spc_pkg::LIMIT_WIDTH-1:0];
                spc_pkg::REG_CONFIRM:        confirm_reg   <= pwdata[spc_pkg::COUNT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            spc_pkg::REG_POSITION_LIMIT: prdata = spc_pkg::DATA_WIDTH'(limit_reg);
            spc_pkg::REG_TOLERANCE:      prdata = spc_pkg::DATA_WIDTH'(tolerance_reg);
            spc_pkg::REG_CONFIRM:        prdata = spc_pkg::DATA_WIDTH'(confirm_reg);
            default:                     prdata = '0;
        endcase
    end

    assign cfg.position_limit = limit_reg;
    assign cfg.tolerance      = tolerance_reg;
    assign cfg.confirm        = confirm_reg;

endmodule

`default_nettype wire

FILE: hdl/spc_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// no package dependencies
`default_nettype none

module spc_div #(
    parameter int DIVIDEND_WIDTH = 33,
    parameter int DIVISOR_WIDTH  = 9
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [DIVIDEND_WIDTH-1:0] dividend,
    input  wire logic [DIVISOR_WIDTH-1:0]  divisor,
    output logic      [DIVIDEND_WIDTH-1:0] quotient,
    output logic                           done
);

    localparam int CW = $clog2(DIVIDEND_WIDTH);

    logic [DIVIDEND_WIDTH-1:0] quo_reg;
    logic [DIVISOR_WIDTH-1:0]  rem_reg;
    logic [DIVISOR_WIDTH-1:0]  den_reg;
    logic [CW-1:0]             cnt_reg;
    logic                      busy_reg;
    logic [DIVISOR_WIDTH:0]    rem_shift;
    logic [DIVISOR_WIDTH:0]    rem_sub;
    logic                      fits;

    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_WIDTH-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};
    assign rem_sub   = rem_shift - {1'b0, den_reg};
    assign done      = busy_reg && (cnt_reg == CW'(DIVIDEND_WIDTH - 1));
    assign quotient  = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            if (done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_WIDTH-2:0], fits};
            rem_reg <= fits ? rem_sub[DIVISOR_WIDTH-1:0] : rem_shift[DIVISOR_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/spc_datapath.sv
// datapath: word latch, checks, running mean and capture state
// depends on spc_pkg and spc_div
`default_nettype none

module spc_datapath #(
    parameter int POSITION_WIDTH        = spc_pkg::POSITION_WIDTH_DEF,
    parameter int AVERAGE_FRACTION_BITS = spc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire spc_pkg::cmd_t                         cmd,
    output spc_pkg::status_t                           status,
    input  wire spc_pkg::cfg_t                         cfg,
    input  wire logic        [spc_pkg::MODE_WIDTH-1:0] mode,
    input  wire logic                                  frame_fresh,
    input  wire logic        [spc_pkg::SEQ_WIDTH-1:0]  frame_sequence,
    input  wire logic                                  position_valid,
    input  wire logic signed [POSITION_WIDTH-1:0]      position,
    output logic             [spc_pkg::PHASE_WIDTH-1:0] phase,
    output logic             [spc_pkg::COUNT_WIDTH-1:0] stable_frames,
    output logic signed      [POSITION_WIDTH-1:0]      captured_target
);

    localparam int P  = POSITION_WIDTH;
    localparam int F  = AVERAGE_FRACTION_BITS;
    localparam int AW = P + F;
    localparam int DW = AW + 1;
    localparam int TW = (DW > spc_pkg::LIMIT_WIDTH + F) ? DW : spc_pkg::LIMIT_WIDTH + F;
    localparam int LW = (P > spc_pkg::LIMIT_WIDTH) ? P : spc_pkg::LIMIT_WIDTH;
    localparam int QW = spc_pkg::COUNT_WIDTH + 1;
    localparam logic [AW:0] BIAS = (AW + 1)'((64'd1 << F) - 64'd1);

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_START,
        ACT_CANCEL,
        ACT_CLEAR,
        ACT_ZERO,
        ACT_RESTART,
        ACT_MEAN
    } act_t;

    // latched word
    logic [spc_pkg::MODE_WIDTH-1:0] mode_in_reg;
    logic                           fresh_in_reg;
    logic [spc_pkg::SEQ_WIDTH-1:0]  seq_in_reg;
    logic                           valid_in_reg;
    logic signed [P-1:0]            pos_in_reg;

    // capture state
    logic [spc_pkg::PHASE_WIDTH-1:0] phase_reg, phase_next;
    logic [spc_pkg::COUNT_WIDTH-1:0] count_reg, count_next;
    logic                            seen_reg, seen_next;
    logic [spc_pkg::SEQ_WIDTH-1:0]   prev_reg, prev_next;
    logic signed [AW-1:0]            avg_reg, avg_next;
    logic signed [P-1:0]             target_reg, target_next;

    // working values
    logic signed [AW-1:0]            scaled;
    logic [P-1:0]                    pos_abs;
    logic signed [DW-1:0]            diff_reg;
    logic                            bad_reg;
    logic [DW-1:0]                   mag;
    logic                            too_far;
    act_t                            action, action_reg;
    logic signed [AW-1:0]            sum_reg;
    logic [DW-1:0]                   quotient;
    logic [QW-1:0]                   divisor;
    logic                            div_done;
    logic [spc_pkg::COUNT_WIDTH-1:0] count_inc;
    logic signed [AW:0]              biased;

    assign scaled  = AW'(pos_in_reg) <<< F;
    assign pos_abs = pos_in_reg[P-1] ? P'(-pos_in_reg) : P'(pos_in_reg);
    assign mag     = diff_reg[DW-1] ? DW'(-diff_reg) : DW'(diff_reg);
    assign too_far = TW'(mag) > (TW'(cfg.tolerance) << F);
    assign divisor = {1'b0, count_reg} + QW'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_in_reg  <= mode;
            fresh_in_reg <= frame_fresh;
            seq_in_reg   <= frame_sequence;
            valid_in_reg <= position_valid;
            pos_in_reg   <= position;
        end
        if (cmd.eval)
        begin
            diff_reg <= DW'(scaled) - DW'(avg_reg);
            bad_reg  <= !valid_in_reg || (LW'(pos_abs) > LW'(cfg.position_limit));
        end
        if (cmd.check)
        begin
            action_reg <= action;
        end
        if (cmd.accum)
        begin
            // quotient truncated toward zero, sign follows the difference
            sum_reg <= AW'(diff_reg[DW-1] ? DW'(avg_reg) - quotient : DW'(avg_reg) + quotient);
        end
    end

    always_comb
    begin
        action = ACT_NONE;
        case (mode_in_reg)
            spc_pkg::MODE_START:  action = ACT_START;
            spc_pkg::MODE_CANCEL: action = ACT_CANCEL;
            spc_pkg::MODE_FRAME:
            begin
                if (phase_reg == spc_pkg::PHASE_CAPTURING)
                begin
                    if (!fresh_in_reg)
                        action = ACT_CLEAR;
                    else if (seen_reg && (seq_in_reg == prev_reg))
                        action = ACT_NONE;
                    else if (bad_reg)
                        action = ACT_ZERO;
                    else if ((count_reg == '0) || too_far)
                        action = ACT_RESTART;
                    else
                        action = ACT_MEAN;
                end
            end
            default: action = ACT_NONE;
        endcase
    end

    spc_div #(
        .DIVIDEND_WIDTH (DW),
        .DIVISOR_WIDTH  (QW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (mag),
        .divisor  (divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    assign status.mean     = (action == ACT_MEAN);
    assign status.div_done = div_done;

    assign count_inc = (count_reg == spc_pkg::COUNT_MAX) ? count_reg
                                                         : count_reg + spc_pkg::COUNT_WIDTH'(1);
    assign biased    = (AW + 1)'(sum_reg) + (sum_reg[AW-1] ? BIAS : '0);

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        seen_next   = seen_reg;
        prev_next   = prev_reg;
        avg_next    = avg_reg;
        target_next = target_reg;
        case (action_reg)
            ACT_START:
            begin
                phase_next  = spc_pkg::PHASE_CAPTURING;
                count_next  = '0;
                seen_next   = 1'b0;
                prev_next   = '0;
                avg_next    = '0;
                target_next = '0;
            end
            ACT_CANCEL:
            begin
                phase_next = spc_pkg::PHASE_IDLE;
                count_next = '0;
                seen_next  = 1'b0;
                prev_next  = '0;
                avg_next   = '0;
            end
            ACT_CLEAR:
            begin
                count_next = '0;
                seen_next  = 1'b0;
                prev_next  = '0;
                avg_next   = '0;
            end
            ACT_ZERO:
            begin
                seen_next  = 1'b1;
                prev_next  = seq_in_reg;
                count_next = '0;
                avg_next   = '0;
            end
            ACT_RESTART:
            begin
                seen_next  = 1'b1;
                prev_next  = seq_in_reg;
                count_next = spc_pkg::COUNT_WIDTH'(1);
                avg_next   = scaled;
            end
            ACT_MEAN:
            begin
                seen_next  = 1'b1;
                prev_next  = seq_in_reg;
                count_next = count_inc;
                avg_next   = sum_reg;
                if (count_inc >= cfg.confirm)
                begin
                    target_next = biased[F+P-1:F];
                    phase_next  = spc_pkg::PHASE_CAPTURED;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= spc_pkg::PHASE_IDLE;
            count_reg  <= '0;
            seen_reg   <= 1'b0;
            prev_reg   <= '0;
            avg_reg    <= '0;
            target_reg <= '0;
        end
        else if (cmd.commit)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            seen_reg   <= seen_next;
            prev_reg   <= prev_next;
            avg_reg    <= avg_next;
            target_reg <= target_next;
        end
    end

    assign phase           = phase_reg;
    assign stable_frames   = count_reg;
    assign captured_target = target_reg;

endmodule

`default_nettype wire

FILE: hdl/spc_ctrl.sv
// controller: sequences one word through check, divide and commit, owns out_valid
// depends on spc_pkg
`default_nettype none

module spc_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output spc_pkg::cmd_t         cmd,
    input  wire spc_pkg::status_t status
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EVAL   = 6'b000010,
        S_CHECK  = 6'b000100,
        S_DIV    = 6'b001000,
        S_ACCUM  = 6'b010000,
        S_COMMIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd.load      = (state_reg == S_IDLE) && in_valid;
        cmd.eval      = (state_reg == S_EVAL);
        cmd.check     = (state_reg == S_CHECK);
        cmd.div_start = (state_reg == S_CHECK) && status.mean;
        cmd.accum     = (state_reg == S_ACCUM);
        cmd.commit    = (state_reg == S_COMMIT) && slot_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_EVAL;
            S_EVAL:   state_next = S_CHECK;
            S_CHECK:  state_next = status.mean ? S_DIV : S_COMMIT;
            S_DIV:    if (status.div_done) state_next = S_ACCUM;
            S_ACCUM:  state_next = S_COMMIT;
            S_COMMIT: if (slot_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: hdl/spc_checker.sv
// port-level checks on the stable position capture block, bound to the top level
// depends on spc_pkg and stable_position_capture
`default_nettype none

module spc_checker #(
    parameter int POSITION_WIDTH = spc_pkg::POSITION_WIDTH_DEF
) (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_ready,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic [spc_pkg::PHASE_WIDTH-1:0]  phase,
    input wire logic [spc_pkg::COUNT_WIDTH-1:0]  stable_frames,
    input wire logic [POSITION_WIDTH-1:0]        captured_target
);

    // one word in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a word is in work");

    // idle is only reached with the samples cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (phase == spc_pkg::PHASE_IDLE) |-> (stable_frames == '0))
        else $error("idle result with a nonzero frame count");

    // capture needs at least two stable frames
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (phase == spc_pkg::PHASE_CAPTURED) |-> (stable_frames >= 8'd2))
        else $error("captured with fewer than two stable frames");

    // a target is only latched when leaving capturing
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (phase == spc_pkg::PHASE_CAPTURING) |-> (captured_target == '0))
        else $error("nonzero target while capturing");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(stable_frames)
            && $stable(captured_target))
        else $error("stalled result word changed");

endmodule

bind stable_position_capture spc_checker #(.POSITION_WIDTH(POSITION_WIDTH)) u_checker (.*);

`default_nettype wire
